/* rtl/wbps_pkg.sv */
// Shared constants and types for the wildcard byte pattern scanner.
package wbps_pkg;

   localparam int MAX_PATTERN_DEFAULT  = 32;
   localparam int OFFSET_WIDTH_DEFAULT = 32;

   localparam int PATTERN_BYTES     = 32;
   localparam int CSR_INDEX_WIDTH   = 3;
   localparam int CSR_DATA_WIDTH    = 64;
   localparam int MATCH_OFFSET_BITS = 32;
   localparam int LENGTH_REG_BITS   = 6;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PATTERN_0_7   = 3'd0,
      CSR_PATTERN_8_15  = 3'd1,
      CSR_PATTERN_16_23 = 3'd2,
      CSR_PATTERN_24_31 = 3'd3,
      CSR_WILDCARD_MASK = 3'd4,
      CSR_PATTERN_LEN   = 3'd5
   } csr_index_type;

endpackage

/* rtl/wildcard_byte_pattern_scanner.sv */
// Wildcard byte pattern scanner: top level with window compare and result register.
// Usage
//   req_*  : one buffer byte per transaction (tdata = data_byte, tlast = end of buffer).
//   rsp_*  : one result transaction when a match ends on the byte, the byte ends the
//            buffer, or both. tdata = start offset of the match (0 when no match),
//            tuser = match found, tlast = buffer done. Bytes that neither complete a
//            match nor end the buffer give no transaction.
//   csr_*  : register writes (0..3 pattern bytes, 4 wildcard mask, 5 pattern length).
//            Write only while the scanner is idle; csr_ready is always high.
// Throughput
//   One byte per cycle while req_tready is high. The newest pattern_length bytes are
//   compared with the pattern in parallel in the cycle the byte is taken, and the result
//   is registered, so it appears on rsp_* in the cycle after the req_* transaction.
// Back-pressure
//   A single output register holds the pending result; req_tready stays high while
//   that register is empty or is being drained in the same cycle. A stalled receiver
//   therefore stalls input only once a result is waiting.
// Reset
//   Synchronous, active high: pattern bytes and mask clear, length returns to 1, the
//   window empties and the buffer offset returns to zero. No clearing pass is needed.
// Matches never overlap (window refills from empty); the offset saturates at all ones.
module wildcard_byte_pattern_scanner #(
   parameter int MAX_PATTERN  = wbps_pkg::MAX_PATTERN_DEFAULT,
   parameter int OFFSET_WIDTH = wbps_pkg::OFFSET_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,  // [7:0] data_byte
   input  logic                                  req_tlast,  // end_of_buffer
   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [wbps_pkg::MATCH_OFFSET_BITS-1:0] rsp_tdata, // [31:0] match_offset
   output logic                                  rsp_tuser,  // [0] match_found
   output logic                                  rsp_tlast,  // buffer_done
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [wbps_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [wbps_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import wbps_pkg::*;

   localparam int LEN_W      = $clog2(MAX_PATTERN + 1);
   localparam int HIST_DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
   localparam int HIST_IDX_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

   // ---------------------------------------------------------------- registers
   logic [PATTERN_BYTES-1:0][7:0]   pattern_ff;
   logic [PATTERN_BYTES-1:0]        wildcard_ff;
   logic [LENGTH_REG_BITS-1:0]      length_ff;

   logic [HIST_DEPTH-1:0][7:0]      hist_ff;     // previous bytes, newest in entry 0
   logic [LEN_W-1:0]                fill_ff, fill_in;
   logic [OFFSET_WIDTH-1:0]         pos_ff, pos_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_match_ff;
   logic                            rsp_done_ff;
   logic [MATCH_OFFSET_BITS-1:0]    rsp_offset_ff;

   // ---------------------------------------------------------------- handshakes
   logic accept;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff  <= '0;
         wildcard_ff <= '0;
         length_ff   <= LENGTH_REG_BITS'(1);
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_0_7:   pattern_ff[7:0]   <= csr_data;
            CSR_PATTERN_8_15:  pattern_ff[15:8]  <= csr_data;
            CSR_PATTERN_16_23: pattern_ff[23:16] <= csr_data;
            CSR_PATTERN_24_31: pattern_ff[31:24] <= csr_data;
            CSR_WILDCARD_MASK: wildcard_ff       <= csr_data[PATTERN_BYTES-1:0];
            CSR_PATTERN_LEN:   length_ff         <= csr_data[LENGTH_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective length: zero counts as one, clamp to the window size
   logic [LEN_W-1:0] len_eff;
   always_comb begin
      if (length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if ({1'b0, length_ff} > (LENGTH_REG_BITS+1)'(MAX_PATTERN)) begin
         len_eff = LEN_MAX;
      end else begin
         len_eff = LEN_W'(length_ff);
      end
   end

   // ---------------------------------------------------------------- window compare
   logic [7:0]             cur_byte;
   logic                   window_full;
   logic [MAX_PATTERN-1:0] byte_ok;
   logic                   match;

   assign cur_byte    = req_tdata;
   assign window_full = ({1'b0, fill_ff} + (LEN_W+1)'(1)) >= {1'b0, len_eff};

   // pattern byte i lines up with the byte received len-1-i bytes ago
   always_comb begin
      logic [LEN_W-1:0] back;
      logic [LEN_W-1:0] hidx;
      logic [7:0]       w;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         back = len_eff - LEN_W'(i) - LEN_W'(1);
         hidx = back - LEN_W'(1);
         w    = (back == '0) ? cur_byte : hist_ff[hidx[HIST_IDX_W-1:0]];
         if (LEN_W'(i) >= len_eff) begin
            byte_ok[i] = 1'b1;
         end else begin
            byte_ok[i] = wildcard_ff[i] || (w == pattern_ff[i]);
         end
      end
   end

   assign match = window_full && (&byte_ok);

   // start offset, modulo the counter width, then fitted to the result field
   logic [OFFSET_WIDTH-1:0]                   start_pos;
   logic [OFFSET_WIDTH+MATCH_OFFSET_BITS-1:0] start_ext;
   assign start_pos = pos_ff - OFFSET_WIDTH'(len_eff - LEN_W'(1));
   assign start_ext = {{MATCH_OFFSET_BITS{1'b0}}, start_pos};

   // ---------------------------------------------------------------- state update
   always_comb begin
      if (match || req_tlast) begin
         fill_in = '0;
      end else if (fill_ff < LEN_MAX) begin
         fill_in = fill_ff + LEN_W'(1);
      end else begin
         fill_in = fill_ff;
      end

      if (req_tlast) begin
         pos_in = '0;
      end else if (pos_ff != '1) begin
         pos_in = pos_ff + OFFSET_WIDTH'(1);
      end else begin
         pos_in = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         pos_ff  <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
         pos_ff  <= pos_in;
      end
   end

   // history shift line, payload only
   always_ff @(posedge clock) begin
      if (accept) begin
         hist_ff[0] <= cur_byte;
         for (int k = 1; k < HIST_DEPTH; k++) begin
            hist_ff[k] <= hist_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- result register
   assign rsp_valid_in = accept ? (match || req_tlast) : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (match || req_tlast)) begin
         rsp_match_ff  <= match;
         rsp_done_ff   <= req_tlast;
         rsp_offset_ff <= match ? start_ext[MATCH_OFFSET_BITS-1:0] : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_offset_ff;
   assign rsp_tuser  = rsp_match_ff;
   assign rsp_tlast  = rsp_done_ff;

   // ---------------------------------------------------------------- checks
`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LEN_MAX)
      else $error("window fill above pattern capacity");

   a_result_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_match_ff || rsp_done_ff))
      else $error("result carries neither match nor buffer end");

   a_buffer_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (pos_ff == '0 && fill_ff == '0 && rsp_valid_ff && rsp_done_ff))
      else $error("buffer end did not restart window and offset");

   a_match_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && match) |=> (fill_ff == '0 && rsp_match_ff))
      else $error("match did not empty the window");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for the wildcard byte pattern scanner.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wbps_pkg::*;

   localparam int unsigned STALL_LIMIT = 3000;  // cycles with no transaction at all

   // one scan result as the block reports it
   typedef struct packed {
      bit        found;
      bit [31:0] offset;
      bit        done;
   } scan_result_type;

   // Scanner model: own copy of pattern, window and offset; queue of results still owed.
   class scan_predictor_type;
      bit [7:0]        pattern [PATTERN_BYTES];
      bit [31:0]       any_mask;
      bit [5:0]        len_reg;
      bit [7:0]        history [PATTERN_BYTES];   // previous bytes, newest first
      bit [31:0]       position;
      int unsigned     fill;
      scan_result_type owed [$];
      int unsigned     errors;

      function new();
         foreach (pattern[i]) pattern[i] = '0;
         foreach (history[i]) history[i] = '0;
         any_mask = '0;
         len_reg  = 6'd1;
         position = '0;
         fill     = 0;
         errors   = 0;
      endfunction

      function void write_reg(csr_index_type idx, bit [63:0] value);
         case (idx) inside
            CSR_PATTERN_0_7, CSR_PATTERN_8_15, CSR_PATTERN_16_23, CSR_PATTERN_24_31: begin
               for (int b = 0; b < 8; b++) pattern[int'(idx) * 8 + b] = value[8*b +: 8];
            end
            CSR_WILDCARD_MASK: any_mask = value[31:0];
            CSR_PATTERN_LEN:   len_reg  = value[5:0];
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return owed.size();
      endfunction

      // one byte taken by the block
      function void note_byte(bit [7:0] cur, bit last);
         int unsigned     len;
         int unsigned     back;
         bit              hit;
         bit [7:0]        w;
         scan_result_type res;
         // zero length behaves as one, oversize lengths clamp to the window size
         len = (len_reg == 0) ? 1 : ((len_reg > MAX_PATTERN_DEFAULT) ? MAX_PATTERN_DEFAULT
                                                                      : len_reg);
         hit = 1'b0;
         // only a window filled entirely since the last flush may match
         if (fill + 1 >= len) begin
            hit = 1'b1;
            for (int i = 0; i < len; i++) begin
               back = len - 1 - i;
               w    = (back == 0) ? cur : history[back - 1];
               if (!any_mask[i] && w != pattern[i]) hit = 1'b0;
            end
         end
         res.found  = hit;
         res.offset = hit ? position - 32'(len - 1) : '0;
         res.done   = last;
         for (int i = PATTERN_BYTES - 1; i > 0; i--) history[i] = history[i - 1];
         history[0] = cur;
         // matches never overlap: window flushes on a hit and on buffer end
         if (hit || last) fill = 0;
         else if (fill < MAX_PATTERN_DEFAULT) fill++;
         if (last) position = '0;
         else if (position != '1) position++;
         if (hit || last) owed.insert(owed.size(), res);
      endfunction

      function void complain(string what, longint unsigned want, longint unsigned got);
         errors++;
         $display("%0t ns: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      endfunction

      // one result transaction taken from the block
      function void check_result(bit found, bit [31:0] offset, bit done);
         scan_result_type want;
         if (owed.size() == 0) begin
            errors++;
            $display("%0t ns: result transaction with none expected: expected none, %s",
                     $time, "got");
            $display("   found=%0d offset=%0h done=%0d", found, offset, done);
            return;
         end
         want = owed.pop_front();
         if (found  != want.found)  complain("match_found",  want.found,  found);
         if (offset != want.offset) complain("match_offset", want.offset, offset);
         if (done   != want.done)   complain("buffer_done",  want.done,   done);
      endfunction
   endclass

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [7:0]                   req_tdata  = '0;   // [7:0] data_byte
   logic                         req_tlast  = 1'b0; // end_of_buffer
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [MATCH_OFFSET_BITS-1:0] rsp_tdata;         // [31:0] match_offset
   logic                         rsp_tuser;         // [0] match_found
   logic                         rsp_tlast;         // buffer_done
   logic                         csr_valid  = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]    csr_data   = '0;

   scan_predictor_type predictor;
   bit                 calm = 1'b0;   // set: no gaps on the input side, receiver always ready
   int unsigned        idle_cycles = 0;

   // stimulus-side view of the configuration being applied
   bit [7:0]    gen_pattern [PATTERN_BYTES];
   bit [31:0]   gen_mask;
   bit [5:0]    gen_len_reg;
   int unsigned gen_len;
   bit [7:0]    alpha [4];
   bit          narrow;          // data drawn mostly from a four-byte alphabet

   wildcard_byte_pattern_scanner i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Transaction monitor: values sampled here are the pre-edge ones, as every
   // driver updates with nonblocking assignments. Results are checked before the
   // new byte is noted so a stray result cannot consume this byte's expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) predictor.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) predictor.note_byte(req_tdata, req_tlast);
         if (csr_valid && csr_ready)
            predictor.write_reg(csr_index_type'(csr_index), csr_data);
      end
   end

   // watchdog: a hung handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // mostly short pauses, now and then a long one
   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return $urandom_range(1, 2);
      if (r < 93) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // receiver: ready runs broken by stalls, none while calm
   initial begin
      while (reset) @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         if (!calm) begin
            rsp_tready <= 1'b0;
            repeat (idle_length()) @(posedge clock);
         end
      end
   end

   // Called at a rising edge; returns at the edge that takes the byte. Valid is
   // left high so back-to-back bytes need no second assignment in one step.
   task automatic send_byte(bit [7:0] data, bit last);
      if (!calm && $urandom_range(0, 99) >= 55) begin
         req_tvalid <= 1'b0;
         repeat (idle_length()) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_buffer(bit [7:0] bytes [$]);
      foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
   endtask

   // Register writes only once every owed result has come back, with margin for a
   // byte that gives no result to pass through the block.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (predictor.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, bit [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_config();
      bit [63:0] word;
      wait_idle();
      for (int r = 0; r < 4; r++) begin
         for (int b = 0; b < 8; b++) word[8*b +: 8] = gen_pattern[r * 8 + b];
         write_reg(csr_index_type'(r), word);
      end
      write_reg(CSR_WILDCARD_MASK, {32'd0, gen_mask});
      write_reg(CSR_PATTERN_LEN, {58'd0, gen_len_reg});
      csr_valid <= 1'b0;
      gen_len = (gen_len_reg == 0) ? 1 : ((gen_len_reg > 32) ? 32 : gen_len_reg);
   endtask

   // first phases pin the extremes, the rest are drawn at random
   task automatic choose_config(int p);
      int unsigned r;
      narrow = ($urandom_range(0, 9) < 7);
      foreach (alpha[i]) alpha[i] = 8'($urandom);
      foreach (gen_pattern[i]) gen_pattern[i] = narrow ? alpha[$urandom_range(0, 3)]
                                                       : 8'($urandom);
      r = $urandom_range(0, 9);
      gen_len_reg = (r == 0) ? 6'd0 : (r == 1) ? 6'd1 : (r == 2) ? 6'd32 :
                    (r == 3) ? 6'($urandom_range(33, 63)) :
                    (r < 6)  ? 6'($urandom_range(2, 4)) : 6'($urandom_range(1, 32));
      r = $urandom_range(0, 5);
      gen_mask = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : (r == 2) ? $urandom
                                  : ($urandom & $urandom & $urandom);
      case (p)
         0: begin
            gen_len_reg = 6'd32;
            gen_mask    = 32'h0;
            foreach (gen_pattern[i]) gen_pattern[i] = 8'($urandom);
         end
         1: begin
            gen_len_reg = 6'd63;
            gen_mask    = 32'hFFFF_FFFF;
            foreach (gen_pattern[i]) gen_pattern[i] = 8'h00;
         end
         2: begin
            gen_len_reg = 6'd1;
            gen_mask    = 32'h0;
            foreach (gen_pattern[i]) gen_pattern[i] = 8'hFF;
         end
         default: ;
      endcase
   endtask

   function automatic bit [7:0] noise_byte();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return gen_pattern[$urandom_range(0, gen_len - 1)];
      if (narrow && r < 80) return alpha[$urandom_range(0, 3)];
      return 8'($urandom);
   endfunction

   function automatic int unsigned buffer_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(100, 400);
      return $urandom_range(1, 2 * gen_len + 8);
   endfunction

   // Buffers built mostly from pattern copies (wildcard slots random, a few
   // copies with one corrupted byte) separated by noise; the last byte of the
   // phase always closes its buffer.
   task automatic scan_phase(int unsigned count);
      bit [7:0]    seg [$];
      int unsigned buf_left;
      int unsigned k;
      bit [7:0]    b;
      bit          last;
      buf_left = buffer_length();
      for (int unsigned n = 0; n < count; n++) begin
         if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         if (seg.size() == 0) begin
            if ($urandom_range(0, 99) < 60) begin
               for (int i = 0; i < gen_len; i++)
                  seg.insert(seg.size(), gen_mask[i] ? noise_byte() : gen_pattern[i]);
               if ($urandom_range(0, 99) < 15) begin
                  k = $urandom_range(0, gen_len - 1);
                  seg[k] = seg[k] ^ (8'h01 << $urandom_range(0, 7));
               end
            end else begin
               repeat ($urandom_range(1, 6)) seg.insert(seg.size(), noise_byte());
            end
         end
         b = seg.pop_front();
         buf_left--;
         last = (buf_left == 0) || (n == count - 1);
         if (last) buf_left = buffer_length();
         send_byte(b, last);
      end
      calm = 1'b0;
   endtask

   initial begin
      predictor = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: single zero byte, no wildcards
      send_buffer('{8'h00, 8'hFF, 8'h7F});
      send_buffer('{8'h00});                    // match on the closing byte

      // four bytes, second one wildcarded
      foreach (gen_pattern[i]) gen_pattern[i] = 8'h00;
      gen_pattern[0] = 8'hA5;
      gen_pattern[1] = 8'h5A;
      gen_pattern[3] = 8'hFF;
      gen_mask       = 32'h0000_0002;
      gen_len_reg    = 6'd4;
      apply_config();
      send_buffer('{8'hA5, 8'h3C});             // buffer shorter than the pattern
      send_buffer('{8'h11, 8'hA5, 8'h77, 8'h00, 8'hFF, 8'hA5, 8'h00, 8'h00, 8'hFF});

      // repeated byte pattern: hits must not overlap
      gen_pattern[0] = 8'hAA;
      gen_pattern[1] = 8'hAA;
      gen_mask       = 32'h0;
      gen_len_reg    = 6'd2;
      apply_config();
      send_buffer('{8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA});

      // zero length acts as one; wildcard byte 0 hits every byte
      gen_mask    = 32'h0000_0001;
      gen_len_reg = 6'd0;
      apply_config();
      send_buffer('{8'h5A, 8'hC3});

      for (int p = 0; p < 12; p++) begin
         choose_config(p);
         apply_config();
         scan_phase(119);
      end

      // drain, then allow the pipeline latency with margin
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (predictor.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (predictor.errors == 0 && predictor.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
